[hw/rtl/byte_coded_mov_add_cpu_core_macros.svh]
// assertion macros for the byte-coded cpu core
// no dependencies
`ifndef BYTE_CODED_MOV_ADD_CPU_CORE_MACROS_SVH
`define BYTE_CODED_MOV_ADD_CPU_CORE_MACROS_SVH
// implication checked on every clock, off in reset
`define BCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, off in reset
`define BCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/bcc_pkg.sv]
// shared types and constants for the byte-coded cpu core
// no dependencies
package bcc_pkg;
    localparam int MEM_DEPTH_DEF = 65536;
    localparam int REG_WIDTH_DEF = 64;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_HALT  = 3'd1,
        ST_OPC   = 3'd2,
        ST_MODE  = 3'd3,
        ST_REG   = 3'd4,
        ST_RANGE = 3'd5
    } status_t;

    localparam logic [1:0] BUS_WMEM = 2'b00;
    localparam logic [1:0] BUS_EXEC = 2'b01;
    localparam logic [1:0] BUS_WREG = 2'b10;

    localparam logic [7:0] OPC_NOP     = 8'd0;
    localparam logic [7:0] OPC_MOV_REG = 8'd1;
    localparam logic [7:0] OPC_MOV_IMM = 8'd2;
    localparam logic [7:0] OPC_ADD_REG = 8'd3;
    localparam logic [7:0] OPC_ADD_IMM = 8'd4;

    localparam logic [1:0] MODE_RR = 2'b00;
    localparam logic [1:0] MODE_RM = 2'b01;
    localparam logic [1:0] MODE_MR = 2'b10;

    typedef enum logic [3:0] {
        S_IDLE, S_WMEM, S_WREG, S_CHK, S_FOP, S_FMOD, S_DEC, S_FIMM,
        S_EXE, S_MRD, S_MWAIT, S_MOP, S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic wmem_bus;
        logic wreg_bus;
        logic fetch_rd;
        logic cap_opc;
        logic cap_mod;
        logic cap_imm;
        logic data_rd;
        logic data_op;
        logic exec_rr;
        logic set_status;
        status_t status;
        logic done;
    } bcc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       pc_oor;
        logic       wmem_oor;
        logic       sel_zero;
        logic [7:0] opc;
        logic [1:0] mode;
        logic [1:0] fmode;
        logic       src_zero;
        logic       dst_zero;
        logic       fault;
        logic       imm_last;
        logic       addr_oor;
    } bcc_stat_t;
endpackage

[hw/rtl/bcc_ctrl.sv]
// controller state machine of the byte-coded cpu core
// depends on bcc_pkg and the macro header
`include "byte_coded_mov_add_cpu_core_macros.svh"
module bcc_ctrl
    import bcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output bcc_cmd_t  cmd,
    input  bcc_stat_t stat
);
    state_t state_reg, state_next;
    logic   imm_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign imm_f = (stat.opc == OPC_MOV_IMM) || (stat.opc == OPC_ADD_IMM);
    assign busy  = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                unique case (stat.op)
                    BUS_WMEM: state_next = S_WMEM;
                    BUS_WREG: state_next = S_WREG;
                    BUS_EXEC:
                    begin
                        if (stat.pc_oor)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status = ST_HALT;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.fetch_rd = 1'b1;
                            state_next = S_FOP;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status = ST_OPC;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WMEM:
            begin
                cmd.set_status = 1'b1;
                cmd.status = stat.wmem_oor ? ST_RANGE : ST_OK;
                cmd.wmem_bus = !stat.wmem_oor;
                state_next = S_DONE;
            end
            S_WREG:
            begin
                cmd.set_status = 1'b1;
                cmd.status = stat.sel_zero ? ST_REG : ST_OK;
                cmd.wreg_bus = !stat.sel_zero;
                state_next = S_DONE;
            end
            S_FOP:
            begin
                cmd.cap_opc = 1'b1;
                state_next = S_FMOD;
            end
            S_FMOD:
            begin
                if (stat.opc > OPC_ADD_IMM)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status = ST_OPC;
                    state_next = S_DONE;
                end
                else if (stat.opc == OPC_NOP)
                begin
                    cmd.set_status = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.fetch_rd = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.cap_mod = 1'b1;
                state_next = S_EXE;
                // a bad mode ends the item before any immediate byte is fetched
                if (imm_f && (stat.fmode != 2'b11))
                begin
                    cmd.fetch_rd = 1'b1;
                    state_next = S_FIMM;
                end
            end
            S_FIMM:
            begin
                cmd.cap_imm = 1'b1;
                if (!stat.imm_last)
                begin
                    cmd.fetch_rd = 1'b1;
                end
                else
                begin
                    state_next = S_EXE;
                end
            end
            S_EXE:
            begin
                state_next = S_DONE;
                cmd.set_status = 1'b1;
                if (stat.mode == 2'b11)
                begin
                    cmd.status = stat.fault ? ST_RANGE : ST_MODE;
                end
                else if (stat.fault)
                begin
                    cmd.status = ST_RANGE;
                end
                else if (stat.dst_zero || (!imm_f && stat.src_zero))
                begin
                    cmd.status = ST_REG;
                end
                else if (stat.mode == MODE_RR)
                begin
                    cmd.exec_rr = 1'b1;
                end
                else if (stat.addr_oor)
                begin
                    cmd.status = ST_RANGE;
                end
                else
                begin
                    cmd.data_rd = 1'b1;
                    state_next = S_MWAIT;
                end
            end
            S_MWAIT: state_next = S_MOP;
            S_MOP:
            begin
                cmd.data_op = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.done = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    `BCC_ASSERT_NXT(a_start_leaves_idle, clk, rst_n, start && !busy, busy, "start not taken")
    `BCC_ASSERT_NXT(a_done_to_idle, clk, rst_n, cmd.done, !busy, "done not followed by idle")
    `BCC_ASSERT_IMP(a_one_write, clk, rst_n, 1'b1,
        $countones({cmd.wmem_bus, cmd.wreg_bus, cmd.exec_rr, cmd.data_op}) <= 1,
        "two writes at once")
endmodule

[hw/rtl/bcc_dp.sv]
// datapath of the byte-coded cpu core: registers, byte memory, adders
// depends on bcc_pkg
module bcc_dp
    import bcc_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF,
    parameter int REG_WIDTH = REG_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           op,
    input  logic [15:0]          mem_addr,
    input  logic [63:0]          write_data,
    input  logic [2:0]           reg_sel,
    input  bcc_cmd_t             cmd,
    output bcc_stat_t            stat,
    output logic [2:0]           status,
    output logic [REG_WIDTH-1:0] pc_q,
    output logic [REG_WIDTH-1:0] ga_q,
    output logic [REG_WIDTH-1:0] gb_q,
    output logic [REG_WIDTH-1:0] gc_q,
    output logic [REG_WIDTH-1:0] gd_q,
    output logic [REG_WIDTH-1:0] bp_q,
    output logic [REG_WIDTH-1:0] sp_q
);
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int IMM_BYTES = (REG_WIDTH + 7) / 8;
    localparam int CW = $clog2(IMM_BYTES + 1);
    localparam int XW = (REG_WIDTH > 20) ? REG_WIDTH + 1 : 21;
    localparam logic [XW-1:0] DEPTH_X = XW'(MEM_DEPTH);

    logic [7:0]           mem [MEM_DEPTH];
    logic [7:0]           rd_q;
    logic [REG_WIDTH-1:0] regs_reg [1:7];
    logic [1:0]           op_reg;
    logic [15:0]          maddr_reg;
    logic [63:0]          wdata_reg;
    logic [2:0]           sel_reg;
    logic [7:0]           opc_reg, mod_reg;
    logic [REG_WIDTH-1:0] imm_reg, addr_reg;
    logic [CW-1:0]        icnt_reg;
    logic                 fault_reg, fvalid_reg;
    logic [2:0]           status_reg;
    logic [7:0]           fbyte;
    logic [2:0]           src, dst;
    logic [REG_WIDTH-1:0] sv, dv, addr_src;
    logic                 add_f, imm_f;
    logic [REG_WIDTH-1:0] pc;

    assign pc  = regs_reg[7];
    assign src = mod_reg[5:3];
    assign dst = mod_reg[2:0];
    assign sv  = (src == 3'd0) ? '0 : regs_reg[src];
    assign dv  = (dst == 3'd0) ? '0 : regs_reg[dst];
    assign imm_f = (opc_reg == OPC_MOV_IMM) || (opc_reg == OPC_ADD_IMM);
    assign add_f = (opc_reg == OPC_ADD_REG) || (opc_reg == OPC_ADD_IMM);
    assign addr_src = (mod_reg[7:6] == MODE_RM) ? dv : (imm_f ? imm_reg : sv);
    // fetched byte: zero when pc was past memory
    assign fbyte = fvalid_reg ? rd_q : 8'd0;

    always_ff @(posedge clk)
    begin
        if (cmd.wmem_bus)
        begin
            mem[AW'(maddr_reg)] <= wdata_reg[7:0];
        end
        else if (cmd.data_op && (mod_reg[7:6] == MODE_RM))
        begin
            mem[AW'(addr_reg)] <= add_f ? 8'(rd_q + (imm_f ? imm_reg[7:0] : sv[7:0])) :
                (imm_f ? imm_reg[7:0] : sv[7:0]);
        end
        if (cmd.fetch_rd)
        begin
            rd_q <= mem[AW'(pc)];
        end
        else if (cmd.data_rd)
        begin
            rd_q <= mem[AW'(addr_src)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg <= op;
            maddr_reg <= mem_addr;
            wdata_reg <= write_data;
            sel_reg <= reg_sel;
        end
        if (cmd.cap_opc)
        begin
            opc_reg <= fbyte;
        end
        if (cmd.cap_mod)
        begin
            mod_reg <= fbyte;
            imm_reg <= '0;
            icnt_reg <= '0;
        end
        if (cmd.cap_imm)
        begin
            imm_reg <= (imm_reg << 8) | REG_WIDTH'(fbyte);
            icnt_reg <= icnt_reg + CW'(1);
        end
        if (cmd.data_rd)
        begin
            addr_reg <= addr_src;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 7; i++)
            begin
                regs_reg[i] <= '0;
            end
            fault_reg <= 1'b0;
            fvalid_reg <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                fault_reg <= 1'b0;
            end
            if (cmd.fetch_rd)
            begin
                fvalid_reg <= (XW'(pc) < DEPTH_X);
                if (!(XW'(pc) < DEPTH_X))
                begin
                    fault_reg <= 1'b1;
                end
                regs_reg[7] <= pc + REG_WIDTH'(1);
            end
            if (cmd.wreg_bus)
            begin
                regs_reg[sel_reg] <= wdata_reg[REG_WIDTH-1:0];
            end
            if (cmd.exec_rr)
            begin
                regs_reg[dst] <= add_f ? dv + (imm_f ? imm_reg : sv) : (imm_f ? imm_reg : sv);
            end
            if (cmd.data_op && (mod_reg[7:6] == MODE_MR))
            begin
                regs_reg[dst] <= add_f ? dv + REG_WIDTH'(rd_q) : REG_WIDTH'(rd_q);
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
            else if (cmd.data_op)
            begin
                status_reg <= ST_OK;
            end
        end
    end

    assign stat.op       = op_reg;
    assign stat.pc_oor   = !(XW'(pc) < DEPTH_X);
    assign stat.wmem_oor = !(21'(maddr_reg) < 21'(MEM_DEPTH));
    assign stat.sel_zero = (sel_reg == 3'd0);
    assign stat.opc      = opc_reg;
    assign stat.mode     = mod_reg[7:6];
    assign stat.fmode    = fbyte[7:6];
    assign stat.src_zero = (src == 3'd0);
    assign stat.dst_zero = (dst == 3'd0);
    assign stat.fault    = fault_reg;
    assign stat.imm_last = (icnt_reg == CW'(IMM_BYTES - 1));
    assign stat.addr_oor = !(XW'(addr_src) < DEPTH_X);

    assign status = status_reg;
    assign pc_q = regs_reg[7];
    assign ga_q = regs_reg[1];
    assign gb_q = regs_reg[2];
    assign gc_q = regs_reg[3];
    assign gd_q = regs_reg[4];
    assign bp_q = regs_reg[5];
    assign sp_q = regs_reg[6];
endmodule

[hw/rtl/byte_coded_mov_add_cpu_core.sv]
// top level of the byte-coded mov/add cpu core
// depends on bcc_pkg, bcc_ctrl and bcc_dp
//
// start is taken when busy is low; every item gives one result, shown on the
// result ports for exactly one cycle while done is high; the receiver cannot
// stall, so it must capture the result in that cycle. a new item is taken only
// after the last one is done. a memory write, a register write or a halted
// execute needs no fetch; an instruction is fetched byte by byte from the
// single-port byte memory: nop and a bad opcode end after the opcode byte,
// register forms and an immediate form with a bad mode after the mode byte,
// immediate forms after (REG_WIDTH+7)/8 immediate bytes, and a memory-mode
// access adds a registered data read. memory is not cleared at reset and must
// be written before it is read.
module byte_coded_mov_add_cpu_core
    import bcc_pkg::*;
#(
    parameter int MEM_DEPTH = MEM_DEPTH_DEF,
    parameter int REG_WIDTH = REG_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [1:0]  op,
    input  logic [15:0] mem_addr,
    input  logic [63:0] write_data,
    input  logic [2:0]  reg_sel,
    output logic [2:0]  status,
    output logic [63:0] pc_out,
    output logic [63:0] gpr_a_out,
    output logic [63:0] gpr_b_out,
    output logic [63:0] gpr_c_out,
    output logic [63:0] gpr_d_out,
    output logic [63:0] base_out,
    output logic [63:0] stack_out
);
    bcc_cmd_t  cmd;
    bcc_stat_t stat;
    logic [REG_WIDTH-1:0] pc_q, ga_q, gb_q, gc_q, gd_q, bp_q, sp_q;

    // sequencer: one item at a time
    bcc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // registers, memory and arithmetic
    bcc_dp #(
        .MEM_DEPTH (MEM_DEPTH),
        .REG_WIDTH (REG_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .mem_addr   (mem_addr),
        .write_data (write_data),
        .reg_sel    (reg_sel),
        .cmd        (cmd),
        .stat       (stat),
        .status     (status),
        .pc_q       (pc_q),
        .ga_q       (ga_q),
        .gb_q       (gb_q),
        .gc_q       (gc_q),
        .gd_q       (gd_q),
        .bp_q       (bp_q),
        .sp_q       (sp_q)
    );

    // results are the live registers, zero-extended to the port width
    assign done      = cmd.done;
    assign pc_out    = 64'(pc_q);
    assign gpr_a_out = 64'(ga_q);
    assign gpr_b_out = 64'(gb_q);
    assign gpr_c_out = 64'(gc_q);
    assign gpr_d_out = 64'(gd_q);
    assign base_out  = 64'(bp_q);
    assign stack_out = 64'(sp_q);
endmodule
